@@ design/bce_pkg.sv @@
package bce_pkg;

    localparam int TOP_W    = 7;
    localparam int CHOOSE_W = 8;
    localparam int VALUE_W  = 63;
    localparam int ROW_AW   = 6;
    localparam int ROW_DEPTH = 1 << ROW_AW;

    typedef struct packed {
        logic              re;
        logic [ROW_AW-1:0] addr;
    } t_mem_rd;

    typedef struct packed {
        logic               we;
        logic [ROW_AW-1:0]  addr;
        logic [VALUE_W-1:0] data;
    } t_mem_wr;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_INIT  = 5'b00010,
        S_SWEEP = 5'b00100,
        S_FETCH = 5'b01000,
        S_LOAD  = 5'b10000
    } t_seq_state;

endpackage

@@ design/bce_row_mem.sv @@
module bce_row_mem
    import bce_pkg::*;
(
    input  logic               i_clk,
    input  t_mem_rd            i_rd,
    input  t_mem_wr            i_wr,
    output logic [VALUE_W-1:0] o_rd_data
);

    logic [VALUE_W-1:0] r_row [ROW_DEPTH];
    logic [VALUE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_row[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.re) begin
            r_rd_data <= r_row[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/bce_seq.sv @@
module bce_seq
    import bce_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [TOP_W-1:0]   i_n,
    input  logic [ROW_AW-1:0]  i_k,
    input  logic [VALUE_W-1:0] i_rd_data,
    output t_mem_rd            o_rd,
    output t_mem_wr            o_wr,
    output logic               o_done,
    output logic [VALUE_W-1:0] o_value
);

    t_seq_state         r_state, n_state;
    logic [TOP_W-1:0]   r_n, n_n;
    logic [ROW_AW-1:0]  r_k, n_k;
    logic [TOP_W-1:0]   r_i, n_i;
    logic [ROW_AW-1:0]  r_lim, n_lim;
    logic [ROW_AW-1:0]  r_p, n_p;
    logic               r_issue, n_issue;
    logic               r_pend_vld, n_pend_vld;
    logic [ROW_AW-1:0]  r_pend_addr, n_pend_addr;
    logic [VALUE_W-1:0] r_upper, n_upper;
    logic [TOP_W-1:0]   i_next;
    logic [ROW_AW-1:0]  lim_next;

    // next row and its column limit, min(i, k)
    assign i_next   = r_i + TOP_W'(1);
    assign lim_next = (i_next < {1'b0, r_k}) ? i_next[ROW_AW-1:0] : r_k;

    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_k         = r_k;
        n_i         = r_i;
        n_lim       = r_lim;
        n_p         = r_p;
        n_issue     = r_issue;
        n_pend_vld  = r_pend_vld;
        n_pend_addr = r_pend_addr;
        n_upper     = r_upper;
        o_rd        = '0;
        o_wr        = '0;
        o_done      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_n     = i_n;
                    n_k     = i_k;
                    n_p     = '0;
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                o_wr.we   = 1'b1;
                o_wr.addr = r_p;
                o_wr.data = (r_p == '0) ? VALUE_W'(1) : '0;
                if (r_p == r_k) begin
                    n_state    = S_SWEEP;
                    n_i        = TOP_W'(1);
                    n_lim      = ROW_AW'(1);
                    n_p        = ROW_AW'(1);
                    n_issue    = 1'b1;
                    n_pend_vld = 1'b0;
                end else begin
                    n_p = r_p + ROW_AW'(1);
                end
            end
            S_SWEEP: begin
                // read side walks lim down to 0
                n_pend_vld  = r_issue;
                n_pend_addr = r_p;
                if (r_issue) begin
                    o_rd.re   = 1'b1;
                    o_rd.addr = r_p;
                    if (r_p == '0) begin
                        n_issue = 1'b0;
                    end else begin
                        n_p = r_p - ROW_AW'(1);
                    end
                end
                // write side trails one entry above the returning read
                if (r_pend_vld) begin
                    n_upper = i_rd_data;
                    if (r_pend_addr != r_lim) begin
                        o_wr.we   = 1'b1;
                        o_wr.addr = r_pend_addr + ROW_AW'(1);
                        o_wr.data = r_upper + i_rd_data;
                    end
                    if (r_pend_addr == '0) begin
                        if (r_i == r_n) begin
                            n_state = S_FETCH;
                        end else begin
                            n_i     = i_next;
                            n_lim   = lim_next;
                            n_p     = lim_next;
                            n_issue = 1'b1;
                        end
                    end
                end
            end
            S_FETCH: begin
                o_rd.re   = 1'b1;
                o_rd.addr = r_k;
                n_state   = S_LOAD;
            end
            S_LOAD: begin
                o_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_issue    <= 1'b0;
            r_pend_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_issue    <= n_issue;
            r_pend_vld <= n_pend_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n         <= n_n;
        r_k         <= n_k;
        r_i         <= n_i;
        r_lim       <= n_lim;
        r_p         <= n_p;
        r_pend_addr <= n_pend_addr;
        r_upper     <= n_upper;
    end

    assign o_value = i_rd_data;

`ifndef SYNTHESIS
    a_wr_above_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP && o_rd.re && o_wr.we) |-> (o_wr.addr > o_rd.addr))
        else $error("row write not above concurrent read");

    a_ptr_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP && r_issue) |-> (r_p <= r_lim))
        else $error("read pointer beyond row limit");

    a_done_after_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_FETCH))
        else $error("done without final fetch");
`endif

endmodule

@@ design/binomial_coefficient_engine.sv @@
// Binomial coefficient engine: one request of n and signed k, one result C(n,k).
// Special cases (k outside 1..n-1, or n above MAX_N): result is loaded on accept.
// General case, kf = min(k,n-k): row entries 0..kf initialised, then for each i=1..n
// the row updated from column min(i,kf) to 0, one read a cycle; entry kf then read.
// One request in flight, the next taken while a result waits at the output.
// Synchronous active-low reset clears control only; the row memory is not cleared.
module binomial_coefficient_engine
    import bce_pkg::*;
#(
    parameter int MAX_N = 63
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [TOP_W-1:0]    i_top,
    input  logic [CHOOSE_W-1:0] i_choose,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [VALUE_W-1:0]  o_value,
    output logic                o_out_of_range
);

    localparam logic [TOP_W-1:0] LP_MAX_N = TOP_W'(MAX_N);

    // control
    logic r_busy;
    logic r_pend_vld;
    logic r_out_vld;
    // payload
    logic [VALUE_W-1:0] r_pend_value;
    logic               r_pend_oor;
    logic [VALUE_W-1:0] r_out_value;
    logic               r_out_oor;

    logic                      accept;
    logic                      move;
    logic signed [CHOOSE_W-1:0] k_s;
    logic signed [CHOOSE_W-1:0] n_s;
    logic                      req_oor;
    logic                      req_one;
    logic                      req_zero;
    logic                      req_fast;
    logic [TOP_W-1:0]          k_lo;
    logic [TOP_W-1:0]          k_diff;
    logic [TOP_W-1:0]          k_fold;
    logic [VALUE_W-1:0]        fast_value;

    logic                      seq_start;
    logic                      seq_done;
    logic [VALUE_W-1:0]        seq_value;
    logic [VALUE_W-1:0]        mem_rd_data;
    t_mem_rd                   mem_rd;
    t_mem_wr                   mem_wr;

    assign o_ready = !r_busy;
    assign accept  = i_valid && !r_busy;

    // request decode: range check first, then the trivial values of k
    assign k_s      = $signed(i_choose);
    assign n_s      = $signed({1'b0, i_top});
    assign req_oor  = i_top > LP_MAX_N;
    assign req_one  = (k_s == '0) || (k_s == n_s);
    assign req_zero = (k_s < 0) || (k_s > n_s);
    assign req_fast = req_oor || req_one || req_zero;

    // fold k to the shorter side; only meaningful when 0 < k < n
    assign k_lo   = i_choose[TOP_W-1:0];
    assign k_diff = i_top - k_lo;
    assign k_fold = (k_diff < k_lo) ? k_diff : k_lo;

    always_comb begin
        priority if (req_oor) begin
            fast_value = '0;
        end else if (req_one) begin
            fast_value = VALUE_W'(1);
        end else begin
            fast_value = '0;
        end
    end

    assign seq_start = accept && !req_fast;

    // pending result slot to output register hand-off
    assign move = r_pend_vld && (!r_out_vld || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (move) begin
                r_busy <= 1'b0;
            end
            if ((accept && req_fast) || seq_done) begin
                r_pend_vld <= 1'b1;
            end else if (move) begin
                r_pend_vld <= 1'b0;
            end
            if (move) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && req_fast) begin
            r_pend_value <= fast_value;
            r_pend_oor   <= req_oor;
        end else if (seq_done) begin
            r_pend_value <= seq_value;
            r_pend_oor   <= 1'b0;
        end
        if (move) begin
            r_out_value <= r_pend_value;
            r_out_oor   <= r_pend_oor;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_value        = r_out_value;
    assign o_out_of_range = r_out_oor;

    bce_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (seq_start),
        .i_n       (i_top),
        .i_k       (k_fold[ROW_AW-1:0]),
        .i_rd_data (mem_rd_data),
        .o_rd      (mem_rd),
        .o_wr      (mem_wr),
        .o_done    (seq_done),
        .o_value   (seq_value)
    );

    bce_row_mem u_row_mem (
        .i_clk     (i_clk),
        .i_rd      (mem_rd),
        .i_wr      (mem_wr),
        .o_rd_data (mem_rd_data)
    );

`ifndef SYNTHESIS
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_oor) |-> (r_out_value == '0))
        else $error("range flag with non-zero value");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_ready)
        else $error("second request taken while busy");

    a_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_done |-> (!r_pend_vld && r_busy))
        else $error("coefficient landed on an occupied slot");
`endif

endmodule
